>>> rtl/sha_pkg.sv
// SHA-256 hasher package: item types, round constants, state codes.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,   // taking message items
    ST_PAD,    // writing padding bytes into the block store
    ST_WAIT,   // final compression running
    ST_OUT     // presenting digest words
  } state_e;

  // compression core
  typedef enum logic [2:0] {
    C_IDLE,    // waiting for a block
    C_LOAD,    // loading schedule window and working vars
    C_ROUND,   // running 64 rounds
    C_ADD,     // folding working vars into chain
    C_INIT     // marking chain entries as initial values
  } core_state_e;

  typedef struct packed {
    logic       start;    // begin compression of the stored block
  } comp_ctl_t;

  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top: byte buffer memory, padding sequencer,
// digest output register. Depends on sha_pkg and sha_core.
//
//  channel | dir | payload         | handshake
//  in      | in  | in_item_t       | in_valid_i / in_ready_o
//  out     | out | out_item_t      | out_valid_o / out_ready_i
//
// A byte without end is written into the byte memory; the 64th byte of a
// block starts a compression (load, 64 rounds, fold) that holds the input off.
// End of message writes one padding byte per cycle while the core is idle, up
// to byte 63, runs one or two compressions, then presents 8 words, each read
// from the chain and held until taken; a chain restore precedes the next item.
// Byte memory writes happen only while the core is idle, so they never overlap
// its reads. Reset is asynchronous; the output stage holds under out_ready_i low.
module sha256_byte_stream_hasher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sha_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sha_pkg::out_item_t  out_data_o
);
  sha_pkg::state_e st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic        pend80_q, pend80_d;   // 0x80 marker still to write
  logic        lenblk_q, lenblk_d;   // current block carries the length
  logic [2:0]  oidx_q, oidx_d;
  logic        ovalid_q, ovalid_d;
  logic        rd_pend_q, rd_pend_d;
  logic [31:0] oword_q;

  // byte memory, four byte lanes of 16 words
  logic [31:0] blk_mem [16];
  logic [31:0] wrd_q;
  logic [3:0]  wrd_addr;
  logic        we;
  logic [7:0]  wdata;

  sha_pkg::comp_ctl_t ctl;
  logic        busy, done, reinit;
  logic [31:0] chain_word;
  logic        acc;
  logic [7:0]  len_byte;

  sha_core u_core (
    .clk_i, .rst_ni, .ctl_i(ctl), .busy_o(busy), .done_o(done),
    .wrd_addr_o(wrd_addr), .wrd_data_i(wrd_q),
    .rd_idx_i(oidx_q), .rd_data_o(chain_word),
    .reinit_i(reinit)
  );

  // byte 0 of a word sits in its top lane
  always_ff @(posedge clk_i) begin
    if (we) blk_mem[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wdata;
    wrd_q <= blk_mem[wrd_addr];
  end

  assign in_ready_o = (st_q == sha_pkg::ST_IDLE) && !busy;
  assign acc = in_valid_i && in_ready_o;

  // length byte for positions 56..63, most significant first
  assign len_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];

  // next state and sequencer registers
  always_comb begin
    st_d = st_q; fill_d = fill_q; bits_d = bits_q; len_d = len_q;
    pend80_d = pend80_q; lenblk_d = lenblk_q;
    oidx_d = oidx_q; ovalid_d = ovalid_q; rd_pend_d = 1'b0;
    unique case (st_q)
      sha_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_data_i.byte_valid) begin
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
          end
          if (in_data_i.end_of_message) begin
            len_d    = in_data_i.byte_valid ? bits_q + 64'd8 : bits_q;
            bits_d   = '0;
            pend80_d = 1'b1;
            lenblk_d = 1'b0;
            st_d     = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (!busy) begin
          fill_d   = fill_q + 6'd1;
          pend80_d = 1'b0;
          // length fits in this block when 0x80 lands below byte 56
          if (pend80_q && fill_q < 6'(sha_pkg::LenOffset)) lenblk_d = 1'b1;
          if (fill_q == 6'd63) begin
            if (lenblk_q) st_d = sha_pkg::ST_WAIT;
            else lenblk_d = 1'b1;
          end
        end
      end
      sha_pkg::ST_WAIT: begin
        if (done) begin
          st_d = sha_pkg::ST_OUT;
          oidx_d = 3'd0;
        end
      end
      sha_pkg::ST_OUT: begin
        // per word: issue chain read, capture, present until taken
        if (ovalid_q) begin
          if (out_ready_i) begin
            ovalid_d = 1'b0;
            if (oidx_q == 3'd7) st_d = sha_pkg::ST_IDLE;
            else oidx_d = oidx_q + 3'd1;
          end
        end else if (rd_pend_q) begin
          ovalid_d = 1'b1;
        end else begin
          rd_pend_d = 1'b1;
        end
      end
    endcase
  end

  // memory writes, compression start, chain restore
  always_comb begin
    we = 1'b0;
    wdata = in_data_i.data_byte;
    ctl = '0;
    reinit = 1'b0;
    unique case (st_q)
      sha_pkg::ST_IDLE: begin
        we = acc && in_data_i.byte_valid;
        ctl.start = acc && in_data_i.byte_valid && (fill_q == 6'd63);
      end
      sha_pkg::ST_PAD: begin
        we = !busy;
        ctl.start = !busy && (fill_q == 6'd63);
        if (pend80_q) wdata = sha_pkg::PadByte;
        else if (lenblk_q && fill_q >= 6'(sha_pkg::LenOffset)) wdata = len_byte;
        else wdata = 8'h00;
      end
      sha_pkg::ST_WAIT: begin
      end
      sha_pkg::ST_OUT: begin
        reinit = ovalid_q && out_ready_i && (oidx_q == 3'd7);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sha_pkg::ST_IDLE; fill_q <= '0; bits_q <= '0; len_q <= '0;
      pend80_q <= 1'b0; lenblk_q <= 1'b0;
      oidx_q <= '0; ovalid_q <= 1'b0; rd_pend_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; bits_q <= bits_d; len_q <= len_d;
      pend80_q <= pend80_d; lenblk_q <= lenblk_d;
      oidx_q <= oidx_d; ovalid_q <= ovalid_d; rd_pend_q <= rd_pend_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) oword_q <= chain_word;
  end
  assign out_valid_o = ovalid_q;
  assign out_data_o.digest_word = oword_q;
  assign out_data_o.word_index = oidx_q;
  assign out_data_o.last_word = (oidx_q == 3'd7);

`ifndef SYNTHESIS
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during digest output");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_word) |=> !out_valid_o)
    else $error("output after last word");
  a_fill_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_word) |=> fill_q == 6'd0)
    else $error("fill count not cleared");
`endif
endmodule

>>> rtl/sha_core.sv
// SHA-256 compression core: reads 16 words from a word memory, runs one round
// per cycle, folds into chain words kept in a second memory. Depends on sha_pkg.
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::comp_ctl_t ctl_i,
  output logic               busy_o,
  output logic               done_o,
  // block word memory read port (word address)
  output logic [3:0]         wrd_addr_o,
  input  logic [31:0]        wrd_data_i,
  // chain readout for the digest
  input  logic [2:0]         rd_idx_i,
  output logic [31:0]        rd_data_o,
  input  logic               reinit_i
);
  sha_pkg::core_state_e st_q, st_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] chain_mem [8];
  logic [7:0]  cvalid_q;       // entry holds a written value, else initial
  logic [31:0] c_rdata_q;
  logic [2:0]  c_raddr;
  logic        c_rsel_q;
  logic [2:0]  c_ridx_q;
  logic [31:0] chain_rd;

  // chain read: fold during ADD, working-var load during LOAD, else digest readout
  assign c_raddr = (st_q == sha_pkg::C_ADD)  ? cnt_q[2:0] + 3'd1 :
                   (st_q == sha_pkg::C_LOAD) ? cnt_q[2:0] : rd_idx_i;
  always_ff @(posedge clk_i) begin
    c_rdata_q <= chain_mem[c_raddr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_rsel_q <= 1'b0;
      c_ridx_q <= '0;
    end else begin
      c_rsel_q <= cvalid_q[c_raddr];
      c_ridx_q <= c_raddr;
    end
  end
  assign chain_rd  = c_rsel_q ? c_rdata_q : sha_pkg::init_h(c_ridx_q);
  assign rd_data_o = chain_rd;
  // word i is addressed at cnt==i and arrives at cnt==i+1
  assign wrd_addr_o = (st_q == sha_pkg::C_LOAD) ? cnt_q[3:0] : 4'd0;

  // round logic
  logic [31:0] t1, t2, wnew, s0, s1, wr;
  always_comb begin
    wr = w_q[0];
    s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11) ^
         sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
         sha_pkg::round_k(cnt_q[5:0]) + wr;
    t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // next state
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      sha_pkg::C_IDLE: begin
        if (ctl_i.start) begin
          st_d = sha_pkg::C_LOAD;
          cnt_d = '0;
        end else if (reinit_i) begin
          st_d = sha_pkg::C_INIT;
        end
      end
      sha_pkg::C_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd16) begin
          st_d = sha_pkg::C_ROUND;
          cnt_d = '0;
        end
      end
      sha_pkg::C_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          st_d = sha_pkg::C_ADD;
          cnt_d = 7'h7f;
        end
      end
      sha_pkg::C_ADD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd7) st_d = sha_pkg::C_IDLE;
      end
      sha_pkg::C_INIT: st_d = sha_pkg::C_IDLE;
      default: st_d = sha_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sha_pkg::C_IDLE;
      cnt_q <= '0;
      cvalid_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      if (st_q == sha_pkg::C_ADD && cnt_q != 7'h7f) cvalid_q[cnt_q[2:0]] <= 1'b1;
      if (st_q == sha_pkg::C_INIT) cvalid_q <= '0;
    end
  end

  // datapath: schedule window, working variables, chain writeback
  always_ff @(posedge clk_i) begin
    if (st_q == sha_pkg::C_LOAD) begin
      // word i arrives in cycle cnt==i+1, behind the registered memory read
      if (cnt_q != 7'd0) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wrd_data_i;
      end
      if (cnt_q >= 7'd1 && cnt_q <= 7'd8) v_q[cnt_q[2:0] - 3'd1] <= chain_rd;
    end
    if (st_q == sha_pkg::C_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (st_q == sha_pkg::C_ADD && cnt_q != 7'h7f)
      chain_mem[cnt_q[2:0]] <= chain_rd + v_q[cnt_q[2:0]];
  end

  assign busy_o = (st_q != sha_pkg::C_IDLE);
  assign done_o = (st_q == sha_pkg::C_ADD) && (cnt_q == 7'd7);
endmodule

>>> test/sha256_checker.sv
// Checker for the SHA-256 byte-stream hasher: watches both channels, keeps its
// own hash state, queues expected digest words and compares them. Uses sha_pkg.
`timescale 1ns / 100ps

module sha256_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  sha_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  sha_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 digests_o
);

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]        chain [8];
  logic [7:0]         blk [64];
  logic [6:0]         fill;
  logic [63:0]        msg_bits;
  sha_pkg::out_item_t digest_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = digest_q.size();

  function automatic logic [31:0] rotr(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // one full compression of blk into chain
  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function automatic void push_byte(logic [7:0] b);
    blk[fill[5:0]] = b;
    fill = fill + 7'd1;
    if (fill >= 7'd64) begin
      compress();
      fill = 0;
    end
  endfunction

  // absorb one accepted item; on end of message pad and queue the digest
  function automatic void absorb_item(sha_pkg::in_item_t it);
    logic [63:0]        len;
    sha_pkg::out_item_t o;
    if (it.byte_valid) begin
      push_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (!it.end_of_message) return;
    len = msg_bits;
    push_byte(sha_pkg::PadByte);
    if (fill > 7'(sha_pkg::LenOffset)) while (fill != 0) push_byte(8'h00);
    while (fill < 7'(sha_pkg::LenOffset)) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      o.digest_word    = chain[i];
      o.word_index     = 3'(i);
      o.last_word      = (i == 7);
      digest_q.push_back(o);
    end
    chain = HInit;
    fill = 0;
    msg_bits = 0;
    digests_o++;
  endfunction

  // monitor both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    sha_pkg::out_item_t exp_w;
    if (!rst_ni) begin
      chain = HInit;
      fill = 0;
      msg_bits = 0;
      fails = 0;
      digests_o = 0;
      digest_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) absorb_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected digest word %h idx %0d", out_data_i.digest_word,
                     out_data_i.word_index);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data_i !== exp_w) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       out_data_i.digest_word, out_data_i.word_index,
                       out_data_i.last_word);
          end
        end
      end
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for sha256_byte_stream_hasher: drives byte messages with random
// gaps and output stalls; sha256_checker does the prediction. Uses sha_pkg.
`timescale 1ns / 100ps

module tb;

  localparam int WatchLimit = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sha_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sha_pkg::out_item_t out_data;
  int                 fail_count, pending, digests;
  int                 items_sent = 0;
  int                 idle_cnt = 0;
  bit                 quiet = 1'b0;
  bit                 hold_out = 1'b0;

  always #2 clk_i = ~clk_i;

  sha256_byte_stream_hasher uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  sha256_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .digests_o(digests)
  );

  // offer one item, with an optional random gap first; wait for acceptance
  task automatic send_item(logic [7:0] b, logic bv, logic eom);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // message of n random bytes; optional final-byte end or separate end item
  task automatic send_message(int n, bit end_on_byte);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom), 1'b1, end_on_byte && (i == n - 1));
    if (!end_on_byte || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver: random stall bursts, off in the quiet tail or during a hold-off
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WatchLimit) begin
      $display("** sha256_byte_stream_hasher: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, ignored item, byte with end, extreme bytes
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    // 56 bytes push the length into an extra block; 64 bytes end on a full block
    send_message(56, 1'b1);
    send_message(64, 1'b1);

    // hold off the receiver while further messages queue up
    hold_out = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_out = 1'b0;
      end
      begin
        send_message(3, 1'b1);
        send_message(2, 1'b0);
      end
    join

    // random short messages, with some ignored items mixed in
    while (items_sent < 176) begin
      if (items_sent > 140) quiet = 1'b1;
      n = int'($urandom_range(0, 12));
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_message(n, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items, %0d message digests checked (empty, pad edges, stalls).",
             items_sent, digests);
    if (fail_count == 0) $display("** sha256_byte_stream_hasher: PASSED **");
    else $display("** sha256_byte_stream_hasher: FAILED **");
    $finish;
  end

endmodule

>>> sha256_byte_stream_hasher.f
rtl/sha_pkg.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
test/sha256_checker.sv
test/tb.sv
